// File: rtl/binary32_truncating_adder_unit_defines.svh
// Assertion macros for the binary32 truncating adder unit.
// Depends on nothing; included by the top level.
`ifndef BINARY32_TRUNCATING_ADDER_UNIT_DEFINES_SVH
`define BINARY32_TRUNCATING_ADDER_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define B32A_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define B32A_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: rtl/b32a_pkg.sv
// Package for the binary32 truncating adder unit: field widths and constants.
// Depends on nothing.
package b32a_pkg;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned FracW   = 23;
  localparam int unsigned SigW    = FracW + 1;
  localparam int unsigned ShW     = 5;
  localparam int unsigned DataW   = 64;
  localparam int unsigned OutW    = 40;
  localparam int unsigned Stages  = 4;

  typedef logic [WordW-1:0] word_t;
  typedef logic [SigW-1:0]  sig_t;
  typedef logic [ExpW-1:0]  exp_t;

  typedef struct packed {
    logic  pass;
    word_t pass_val;
    logic  sa;
    logic  sb;
    sig_t  ma;
    sig_t  mb;
    exp_t  er;
  } align_t;

  typedef struct packed {
    logic  pass;
    word_t pass_val;
    logic  zero;
    logic  sr;
    logic  carry;
    logic  sub;
    sig_t  mr;
    exp_t  er;
  } comb_t;

  typedef struct packed {
    word_t sum_bits;
    logic  wrapped;
  } res_t;
endpackage

// File: rtl/b32a_lzc.sv
// Leading zero count over a 24-bit significand.
// Depends on b32a_pkg.
module b32a_lzc (
  input  b32a_pkg::sig_t                  value,
  output logic [b32a_pkg::ShW-1:0]        count
);
  import b32a_pkg::*;

  always_comb begin
    count = '0;
    for (int i = 0; i < int'(SigW); i++) begin
      if (value[i]) begin
        count = ShW'(int'(SigW) - 1 - i);
      end
    end
  end
endmodule

// File: rtl/binary32_truncating_adder_unit.sv
// Channel  | dir | tdata fields (low bit first)
// s_axis   | in  | operand_a[31:0], operand_b[63:32]
// m_axis   | out | sum_bits[31:0], exponent_wrapped[32], zero fill to 40
// Four register stages: unpack/align, add/subtract, normalize, output.
// One beat enters per cycle while s_axis_tready is high; a beat passes s1, s2, s3, s4 in order.
// A stall freezes each stage holding data with no bubble after it; bubbles are squeezed out.
// rst is synchronous and clears the stage valid bits only.
// Depends on b32a_pkg, b32a_lzc and binary32_truncating_adder_unit_defines.svh.
`include "binary32_truncating_adder_unit_defines.svh"
module binary32_truncating_adder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [b32a_pkg::DataW-1:0]    s_axis_tdata,  // operand_a, operand_b
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [b32a_pkg::OutW-1:0]     m_axis_tdata   // sum_bits, exponent_wrapped, 0
);
  import b32a_pkg::*;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] adv;
  align_t s1;
  comb_t  s2;
  res_t   s3, s4;

  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || m_axis_tready;
    for (int i = Stages - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end
  assign s_axis_tready = adv[0];

  // stage 1: zero detect and align
  word_t a, b;
  align_t s1_next;
  logic [ExpW:0] d;
  logic a_lt;
  sig_t ma0, mb0;
  assign a = s_axis_tdata[WordW-1:0];
  assign b = s_axis_tdata[DataW-1:WordW];
  always_comb begin
    ma0 = {1'b1, a[FracW-1:0]};
    mb0 = {1'b1, b[FracW-1:0]};
    a_lt = a[30:23] < b[30:23];
    d = a_lt ? ({1'b0, b[30:23]} - {1'b0, a[30:23]})
             : ({1'b0, a[30:23]} - {1'b0, b[30:23]});
    s1_next.sa = a[31];
    s1_next.sb = b[31];
    s1_next.pass = (a[30:0] == '0) || (b[30:0] == '0);
    s1_next.pass_val = (a[30:0] == '0) ? b : a;
    s1_next.ma = ma0;
    s1_next.mb = mb0;
    if (a_lt) begin
      s1_next.ma = (d >= (ExpW+1)'(SigW)) ? '0 : ma0 >> d[ShW-1:0];
      s1_next.er = b[30:23];
    end else begin
      s1_next.mb = (d >= (ExpW+1)'(SigW)) ? '0 : mb0 >> d[ShW-1:0];
      s1_next.er = a[30:23];
    end
  end

  // stage 2: add or subtract
  comb_t s2_next;
  logic [SigW:0] sum;
  always_comb begin
    sum = {1'b0, s1.ma} + {1'b0, s1.mb};
    s2_next.pass = s1.pass;
    s2_next.pass_val = s1.pass_val;
    s2_next.er = s1.er;
    s2_next.sub = s1.sa != s1.sb;
    s2_next.zero = 1'b0;
    s2_next.carry = 1'b0;
    if (s1.sa == s1.sb) begin
      s2_next.sr = s1.sa;
      s2_next.carry = sum[SigW];
      s2_next.mr = sum[SigW] ? sum[SigW:1] : sum[SigW-1:0];
    end else if (s1.ma > s1.mb) begin
      s2_next.sr = s1.sa;
      s2_next.mr = s1.ma - s1.mb;
    end else begin
      s2_next.sr = s1.sb;
      s2_next.mr = s1.mb - s1.ma;
      s2_next.zero = s1.ma == s1.mb;
    end
  end

  // stage 3: normalize and pack
  logic [ShW-1:0] lz;
  res_t s3_next;
  logic [ExpW+1:0] ew;
  sig_t mn;
  b32a_lzc u_lzc (.value(s2.mr), .count(lz));
  always_comb begin
    mn = s2.mr;
    ew = {2'b00, s2.er};
    if (s2.sub) begin
      mn = s2.mr << lz;
      ew = {2'b00, s2.er} - {5'b0, lz};
    end else if (s2.carry) begin
      ew = {2'b00, s2.er} + 10'd1;
    end
    if (s2.pass) begin
      s3_next.sum_bits = s2.pass_val;
      s3_next.wrapped = 1'b0;
    end else if (s2.zero) begin
      s3_next.sum_bits = '0;
      s3_next.wrapped = 1'b0;
    end else begin
      s3_next.sum_bits = {s2.sr, ew[ExpW-1:0], mn[FracW-1:0]};
      s3_next.wrapped = ew[ExpW+1:ExpW] != 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < int'(Stages); i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
    if (adv[0]) s1 <= s1_next;
    if (adv[1]) s2 <= s2_next;
    if (adv[2]) s3 <= s3_next;
    if (adv[3]) s4 <= s3;
  end

  assign m_axis_tvalid = vld[Stages-1];
  assign m_axis_tdata = {7'b0, s4.wrapped, s4.sum_bits};

  `B32A_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
  `B32A_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid,
                   m_axis_tdata[OutW-1:WordW+1] == '0)
  `B32A_ASSERT_IMP(a_ready, clk, rst, !vld[0], s_axis_tready)
endmodule

// File: test/tb_top.sv
// Testbench for binary32_truncating_adder_unit: drives operand pairs on s_axis,
// predicts each truncated sum and wrap flag, and checks m_axis beats in order.
// Depends on b32a_pkg and the unit RTL.
module tb_top;
  import b32a_pkg::*;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic        wrapped;
  } sum_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;   // operand_a[31:0], operand_b[63:32]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutW-1:0]     m_axis_tdata;   // sum_bits[31:0], exponent_wrapped[32], zero fill

  logic [63:0] operand_q[$];
  sum_t        expected_sums[$];
  int          errors;
  int          sent;
  int          received;
  int          send_wait;
  int          recv_wait;
  int          idle_cycles;
  bit          hold_off;
  bit          in_taken;
  bit          out_taken;

  binary32_truncating_adder_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic sum_t add_truncated(logic [31:0] a, logic [31:0] b);
    sum_t        r;
    logic        sa;
    logic        sb;
    logic        sr;
    int          ea;
    int          eb;
    int          er;
    int          d;
    logic [24:0] ma;
    logic [24:0] mb;
    logic [24:0] mr;
    sa = a[31];
    sb = b[31];
    ea = a[30:23];
    eb = b[30:23];
    r.wrapped = 1'b0;
    if (a[30:0] == '0) begin
      r.sum_bits = b;
      return r;
    end
    if (b[30:0] == '0) begin
      r.sum_bits = a;
      return r;
    end
    ma = {2'b01, a[22:0]};
    mb = {2'b01, b[22:0]};
    if (ea < eb) begin
      d = eb - ea;
      ma = (d >= 24) ? '0 : ma >> d;
      er = eb;
    end else begin
      d = ea - eb;
      mb = (d >= 24) ? '0 : mb >> d;
      er = ea;
    end
    if (sa == sb) begin
      sr = sa;
      mr = ma + mb;
      if (mr[24]) begin
        mr = mr >> 1;
        er++;
      end
    end else begin
      if (ma == mb) begin
        r.sum_bits = '0;
        return r;
      end
      sr = (ma > mb) ? sa : sb;
      mr = (ma > mb) ? ma - mb : mb - ma;
      while (!mr[23]) begin
        mr = mr << 1;
        er--;
      end
    end
    r.sum_bits = {sr, 8'(er), mr[22:0]};
    r.wrapped = (er < 0 || er > 255);
    return r;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0: f[30:0] = '0;
      1: f[30:23] = 8'($urandom_range(0, 2));
      2: f[30:23] = 8'($urandom_range(253, 255));
      3: f[22:0] = $urandom_range(0, 1) ? '0 : 23'h7FFFFF;
      default: f[30:23] = 8'($urandom_range(100, 155));
    endcase
    return f;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    int w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (send_wait > 0) begin
      send_wait <= send_wait - 1;
      s_axis_tvalid <= 1'b0;
    end else if (operand_q.size() > 0 && !(hold_off && expected_sums.size() > 0)) begin
      s_axis_tdata <= operand_q.pop_front();
      s_axis_tvalid <= 1'b1;
      send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    if (!rst) begin
      if (out_taken) begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
        recv_wait <= (w > 0) ? w - 1 : 0;
        m_axis_tready <= (w == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sum_t got;
    sum_t exp_sum;
    if (!rst) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_sums.push_back(add_truncated(s_axis_tdata[31:0], s_axis_tdata[63:32]));
        sent++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        received++;
        got.sum_bits = m_axis_tdata[31:0];
        got.wrapped = m_axis_tdata[32];
        if (expected_sums.size() == 0) begin
          $error("unexpected beat: sum_bits %h", got.sum_bits);
          errors++;
        end else begin
          exp_sum = expected_sums.pop_front();
          if (got.sum_bits !== exp_sum.sum_bits) begin
            $error("sum_bits expected %h actual %h", exp_sum.sum_bits, got.sum_bits);
            errors++;
          end
          if (got.wrapped !== exp_sum.wrapped) begin
            $error("exponent_wrapped expected %b actual %b", exp_sum.wrapped, got.wrapped);
            errors++;
          end
        end
      end
      if (idle_cycles > 2000) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    errors = 0;
    sent = 0;
    received = 0;
    send_wait = 0;
    recv_wait = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    operand_q.push_back({32'h3F800000, 32'h00000000});
    operand_q.push_back({32'h80000000, 32'h40490FDB});
    operand_q.push_back({32'h3F800000, 32'h3F800000});
    operand_q.push_back({32'h7F800000, 32'h7F800000});
    operand_q.push_back({32'h7FFFFFFF, 32'h7FFFFFFF});
    operand_q.push_back({32'hBF800000, 32'h3F800000});
    operand_q.push_back({32'hBF800001, 32'h3F800000});
    operand_q.push_back({32'h00000001, 32'h80000002});
    operand_q.push_back({32'h00800000, 32'h80800001});
    operand_q.push_back({32'h4B000000, 32'h3F800000});
    operand_q.push_back({32'h4C000000, 32'h3F800000});
    operand_q.push_back({32'hC0000000, 32'h3F800001});
    operand_q.push_back({32'hFFFFFFFF, 32'h00000000});
    operand_q.push_back({32'h80000000, 32'h80000000});
    operand_q.push_back({32'h00000001, 32'hFFFFFFFF});
    operand_q.push_back({32'h3FFFFFFF, 32'h3FFFFFFF});
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1550; i++) begin
      a = rand_float();
      b = rand_float();
      if ($urandom_range(0, 4) == 0) begin
        b[30:23] = a[30:23] + 8'($urandom_range(0, 2)) - 8'd1;
        b[31] = ~a[31];
      end
      if (i == 700) begin
        wait (operand_q.size() == 0 && !s_axis_tvalid);
        hold_off = 1'b1;
        wait (expected_sums.size() == 0);
        hold_off = 1'b0;
      end
      operand_q.push_back({b, a});
    end
    wait (operand_q.size() == 0 && !s_axis_tvalid);
    wait (expected_sums.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d additions: zero operands, carries, cancels, wraps, random.", sent);
    $display("Checked %0d result beats under random stalls on both sides.", received);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
